### rtl/qasf_pkg.sv
// Package for the spin-flip annealing engine: request codes, register indexes,
// widths and the acceptance table builder. No dependencies.
`default_nettype none
package qasf_pkg;

	localparam int MAX_SPINS_DEF    = 64;
	localparam int MAX_TROTTERS_DEF = 16;
	localparam int EXP_TABLE_DEPTH  = 256;
	localparam int EXP_IDX_W        = $clog2(EXP_TABLE_DEPTH);
	localparam int RAND_BITS        = 16;

	localparam logic [63:0] EXP_STEP_Q32 = 64'd4162825044;

	localparam logic [2:0] REQ_LOAD_H     = 3'd0;
	localparam logic [2:0] REQ_LOAD_J     = 3'd1;
	localparam logic [2:0] REQ_WRITE_SPIN = 3'd2;
	localparam logic [2:0] REQ_TRIAL      = 3'd3;
	localparam logic [2:0] REQ_READ_SPIN  = 3'd4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_SPINS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_TROTTERS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TWO_DIV_M     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COUPLING_COEF = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_TEMP      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAXIMIZE      = 3'd5;

	typedef logic [15:0] exp_tab_t [EXP_TABLE_DEPTH];

	// Entry i approximates exp(-i/32) in 0.16 format.
	function automatic exp_tab_t build_exp_table();
		logic [127:0] v;
		logic [127:0] e;
		logic [127:0] p;
		exp_tab_t     t;
		v = 128'h1_0000_0000;
		for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
			e = (v + 128'h8000) >> 16;
			t[i] = (e > 128'd65535) ? 16'hFFFF : e[15:0];
			p = v * {64'd0, EXP_STEP_Q32} + 128'h8000_0000;
			v = p >> 32;
		end
		return t;
	endfunction

endpackage
`default_nettype wire

### rtl/qasf_if.sv
// Channel interfaces of the spin-flip engine: request and result channels.
// Each carries valid, ready and the payload fields. No dependencies.
`default_nettype none
interface qasf_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         req_type;
	logic [5:0]         row_index;
	logic [5:0]         col_index;
	logic [3:0]         trotter_index;
	logic signed [31:0] load_value;
	logic               spin_in;
	logic [15:0]        rand_u;

	modport source(output valid, req_type, row_index, col_index, trotter_index,
		load_value, spin_in, rand_u, input ready);
	modport sink(input valid, req_type, row_index, col_index, trotter_index,
		load_value, spin_in, rand_u, output ready);
endinterface

interface qasf_out_if;
	logic               valid;
	logic               ready;
	logic               spin_out;
	logic               flipped;
	logic signed [39:0] delta_energy;

	modport source(output valid, spin_out, flipped, delta_energy, input ready);
	modport sink(input valid, spin_out, flipped, delta_energy, output ready);
endinterface
`default_nettype wire

### rtl/qasf_accept.sv
// Metropolis acceptance for a non-negative energy change: scales by 1/kT,
// looks up the exponential table and compares with the random value. Uses qasf_pkg.
`default_nettype none
module qasf_accept #(
	parameter int DW = 40
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [DW-1:0] d,
	input  wire logic [30:0]   inv_temp,
	input  wire logic [15:0]   rnd,
	output logic               flip
);
	import qasf_pkg::*;

	localparam int HW  = DW + 15;
	localparam int LW  = DW + 16;
	localparam int PRW = DW + 17;
	localparam exp_tab_t EXP_TAB = build_exp_table();
	localparam logic [15:0] RMASK = (RAND_BITS >= 16) ? 16'hFFFF :
		16'((32'd1 << RAND_BITS) - 32'd1);

	logic [HW-1:0]        hi_s1;
	logic [LW-1:0]        lo_s1;
	logic [PRW-1:0]       prod;
	logic [EXP_IDX_W-1:0] k;
	logic [15:0]          thr;
	logic                 in_range;

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s1 <= HW'(d * inv_temp[30:16]);
			lo_s1 <= LW'(d * inv_temp[15:0]);
		end
	end

	always_comb begin
		prod     = PRW'({hi_s1[31:0], 16'd0}) + PRW'(lo_s1);
		k        = prod[27 +: EXP_IDX_W];
		in_range = (hi_s1[HW-1:32] == '0) && (prod[PRW-1:27+EXP_IDX_W] == '0);
		thr      = in_range ? EXP_TAB[k] : 16'd0;
		flip     = {thr, {RAND_BITS{1'b0}}} > {(rnd & RMASK), {RAND_BITS{1'b0}}} >> 0
			&& ({thr, {RAND_BITS{1'b0}}} > (16 + RAND_BITS)'({(rnd & RMASK), 16'd0}));
	end
endmodule
`default_nettype wire

### rtl/quantum_annealing_spin_flip_top.sv
// Top level of the spin-flip annealing engine: register file, field, coupling
// and spin memories, trial sequencer. Uses qasf_pkg, qasf_if and qasf_accept.
//
// Usage: requests arrive on the cmd channel and every request gives exactly one
// result on the rsp channel; a transfer happens when valid and ready are high.
// Configuration is written through cfg_we, cfg_index and cfg_wdata while the
// engine is idle. Loads of h or J and spin writes go from idle straight to the
// finish state, a spin read through a read-wait state. A trial reads one
// coupling word and one spin per cycle while it sums, then passes the neighbour
// read, arithmetic and decision states. Only one request is in work at a time,
// but a new request is taken while the previous result still waits in the
// output register. When the receiver stalls, the finished result holds in the
// sequencer until the output register frees. Reset sets the register file and
// sequencer to their defaults; the memories are undefined until written.
`default_nettype none
module quantum_annealing_spin_flip_top #(
	parameter int MAX_SPINS    = qasf_pkg::MAX_SPINS_DEF,
	parameter int MAX_TROTTERS = qasf_pkg::MAX_TROTTERS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [qasf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [qasf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	qasf_in_if.sink                                cmd,
	qasf_out_if.source                             rsp
);
	import qasf_pkg::*;

	localparam int SW     = $clog2(MAX_SPINS);
	localparam int CAW    = $clog2(MAX_SPINS * MAX_SPINS);
	localparam int AW     = (MAX_SPINS * MAX_TROTTERS > 1) ? $clog2(MAX_SPINS * MAX_TROTTERS) : 1;
	localparam int NW     = ($clog2(MAX_SPINS + 1) > 7) ? $clog2(MAX_SPINS + 1) : 7;
	localparam int ACC_W  = 33 + $clog2(MAX_SPINS + 1);
	localparam int PW     = ACC_W + 20;
	localparam int T1_W   = ACC_W + 4;
	localparam int DE_W   = T1_W + 2;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RDW  = 4'd1;
	localparam logic [3:0] S_SUM  = 4'd2;
	localparam logic [3:0] S_NB0  = 4'd3;
	localparam logic [3:0] S_NB1  = 4'd4;
	localparam logic [3:0] S_NB2  = 4'd5;
	localparam logic [3:0] S_MUL  = 4'd6;
	localparam logic [3:0] S_RND  = 4'd7;
	localparam logic [3:0] S_DE   = 4'd8;
	localparam logic [3:0] S_EXP  = 4'd9;
	localparam logic [3:0] S_DEC  = 4'd10;
	localparam logic [3:0] S_FIN  = 4'd11;

	logic [6:0]         num_spins_q;
	logic [4:0]         num_trotters_q;
	logic [17:0]        two_div_m_q;
	logic signed [31:0] coupling_coef_q;
	logic [30:0]        inv_temp_q;
	logic               maximize_q;

	logic signed [31:0] field_mem [MAX_SPINS];
	logic signed [31:0] cpl_mem   [MAX_SPINS * MAX_SPINS];
	logic               spin_mem  [MAX_SPINS * MAX_TROTTERS];

	logic [3:0]              state_q;
	logic [5:0]              x_q;
	logic [3:0]              y_q;
	logic [NW-1:0]           j_q;
	logic [15:0]             rnd_q;
	logic signed [31:0]      fld_rd_q;
	logic signed [31:0]      cpl_rd_q;
	logic                    spin_rd_q;
	logic                    rd_v_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic                    q_q;
	logic                    s0_q;
	logic                    s1_q;
	logic [37:0]             plo_q;
	logic signed [ACC_W-2:0] phi_q;
	logic signed [T1_W-1:0]  t1_q;
	logic signed [DE_W-1:0]  de_q;
	logic                    res_spin_q;
	logic                    res_flip_q;
	logic signed [39:0]      res_de_q;
	logic                    out_valid_q;
	logic                    out_spin_q;
	logic                    out_flip_q;
	logic signed [39:0]      out_de_q;

	logic [31:0]        n_eff;
	logic [31:0]        m_eff;
	logic               fire;
	logic               spin_ok;
	logic signed [31:0] load_eff;
	logic               sp_we;
	logic [AW-1:0]      sp_waddr;
	logic               sp_wdata;
	logic [AW-1:0]      sp_raddr;
	logic [31:0]        y0;
	logic [31:0]        y1;
	logic               out_free;
	logic               acc_flip;
	logic signed [PW-1:0]   psum;
	logic signed [DE_W-1:0] de_next;
	logic signed [DE_W-1:0] cc2;
	logic signed [39:0]     de_sat;

	function automatic logic [AW-1:0] spin_addr(input logic [31:0] y, input logic [31:0] x);
		return AW'(y * 32'(MAX_SPINS) + x);
	endfunction

	always_comb begin
		if (num_spins_q == 7'd0)
			n_eff = 32'd1;
		else if (32'(num_spins_q) > 32'(MAX_SPINS))
			n_eff = 32'(MAX_SPINS);
		else
			n_eff = 32'(num_spins_q);
		if (num_trotters_q == 5'd0)
			m_eff = 32'd1;
		else if (32'(num_trotters_q) > 32'(MAX_TROTTERS))
			m_eff = 32'(MAX_TROTTERS);
		else
			m_eff = 32'(num_trotters_q);
	end

	assign cmd.ready = (state_q == S_IDLE);
	assign fire      = cmd.valid && cmd.ready;
	assign spin_ok   = (32'(cmd.row_index) < n_eff) && (32'(cmd.trotter_index) < m_eff);
	assign out_free  = !out_valid_q || rsp.ready;

	always_comb begin
		if (!maximize_q)
			load_eff = cmd.load_value;
		else if (cmd.load_value == 32'sh8000_0000)
			load_eff = 32'sh7FFF_FFFF;
		else
			load_eff = -cmd.load_value;
	end

	assign y0 = (y_q == 4'd0) ? m_eff - 32'd1 : 32'(y_q) - 32'd1;
	assign y1 = (32'(y_q) + 32'd1 == m_eff) ? 32'd0 : 32'(y_q) + 32'd1;

	always_comb begin
		unique case (state_q)
			S_SUM:   sp_raddr = spin_addr(32'(y_q), 32'(j_q));
			S_NB0:   sp_raddr = spin_addr(32'(y_q), 32'(x_q));
			S_NB1:   sp_raddr = spin_addr(y0, 32'(x_q));
			S_NB2:   sp_raddr = spin_addr(y1, 32'(x_q));
			default: sp_raddr = spin_addr(32'(cmd.trotter_index), 32'(cmd.row_index));
		endcase
	end

	always_comb begin
		sp_we    = 1'b0;
		sp_waddr = spin_addr(32'(y_q), 32'(x_q));
		sp_wdata = !q_q;
		if (fire && cmd.req_type == REQ_WRITE_SPIN && spin_ok) begin
			sp_we    = 1'b1;
			sp_waddr = spin_addr(32'(cmd.trotter_index), 32'(cmd.row_index));
			sp_wdata = cmd.spin_in;
		end else if (state_q == S_DEC && (de_q < 0 || acc_flip)) begin
			sp_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sp_we)
			spin_mem[sp_waddr] <= sp_wdata;
		spin_rd_q <= spin_mem[sp_raddr];
	end

	always_ff @(posedge clk) begin
		if (fire && cmd.req_type == REQ_LOAD_H && 32'(cmd.row_index) < 32'(MAX_SPINS))
			field_mem[SW'(32'(cmd.row_index))] <= load_eff;
		if (fire)
			fld_rd_q <= field_mem[SW'(32'(cmd.row_index))];
	end

	always_ff @(posedge clk) begin
		if (fire && cmd.req_type == REQ_LOAD_J && 32'(cmd.row_index) < 32'(MAX_SPINS)
				&& 32'(cmd.col_index) < 32'(MAX_SPINS))
			cpl_mem[CAW'(32'(cmd.row_index) * 32'(MAX_SPINS) + 32'(cmd.col_index))] <= load_eff;
		cpl_rd_q <= cpl_mem[CAW'(32'(x_q) * 32'(MAX_SPINS) + 32'(j_q))];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_spins_q     <= 7'd64;
			num_trotters_q  <= 5'd16;
			two_div_m_q     <= 18'd8192;
			coupling_coef_q <= 32'sd0;
			inv_temp_q      <= 31'd65536;
			maximize_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUM_SPINS:     num_spins_q     <= cfg_wdata[6:0];
				CFG_NUM_TROTTERS:  num_trotters_q  <= cfg_wdata[4:0];
				CFG_TWO_DIV_M:     two_div_m_q     <= cfg_wdata[17:0];
				CFG_COUPLING_COEF: coupling_coef_q <= cfg_wdata[31:0];
				CFG_INV_TEMP:      inv_temp_q      <= cfg_wdata[30:0];
				CFG_MAXIMIZE:      maximize_q      <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		psum = (PW'(phi_q) <<< 20) + $signed(PW'(plo_q)) + PW'(32'sd32768);
		cc2  = DE_W'(coupling_coef_q) <<< 1;
		de_next = q_q ? -DE_W'(t1_q) : DE_W'(t1_q);
		if (s0_q == s1_q) begin
			if (q_q == s0_q)
				de_next = de_next - cc2;
			else
				de_next = de_next + cc2;
		end
		if (64'(de_q) > 64'sd549755813887)
			de_sat = 40'sh7F_FFFF_FFFF;
		else if (64'(de_q) < -64'sd549755813888)
			de_sat = 40'sh80_0000_0000;
		else
			de_sat = de_q[39:0];
	end

	qasf_accept #(
		.DW(DE_W - 1)
	) u_accept (
		.clk      (clk),
		.en       (state_q == S_EXP),
		.d        (de_q[DE_W-2:0]),
		.inv_temp (inv_temp_q),
		.rnd      (rnd_q),
		.flip     (acc_flip)
	);

	always_ff @(posedge clk) begin
		rd_v_s1 <= (state_q == S_SUM);
		if (fire) begin
			x_q   <= cmd.row_index;
			y_q   <= cmd.trotter_index;
			rnd_q <= cmd.rand_u;
		end
		if (state_q == S_SUM && j_q == '0)
			acc_q <= ACC_W'(fld_rd_q);
		else if (rd_v_s1)
			acc_q <= spin_rd_q ? acc_q + ACC_W'(cpl_rd_q) : acc_q - ACC_W'(cpl_rd_q);
		if (state_q == S_NB1)
			q_q <= spin_rd_q;
		if (state_q == S_NB2)
			s0_q <= spin_rd_q;
		if (state_q == S_MUL) begin
			s1_q  <= spin_rd_q;
			plo_q <= two_div_m_q * acc_q[19:0];
			phi_q <= (ACC_W-1)'($signed({1'b0, two_div_m_q}) * $signed(acc_q[ACC_W-1:20]));
		end
		if (state_q == S_RND)
			t1_q <= T1_W'(psum >>> 16);
		if (state_q == S_DE)
			de_q <= de_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			j_q         <= '0;
			res_spin_q  <= 1'b0;
			res_flip_q  <= 1'b0;
			res_de_q    <= '0;
			out_valid_q <= 1'b0;
			out_spin_q  <= 1'b0;
			out_flip_q  <= 1'b0;
			out_de_q    <= '0;
		end else begin
			if (out_valid_q && rsp.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (fire) begin
						res_spin_q <= 1'b0;
						res_flip_q <= 1'b0;
						res_de_q   <= '0;
						j_q        <= '0;
						if (cmd.req_type == REQ_WRITE_SPIN && spin_ok)
							res_spin_q <= cmd.spin_in;
						if (cmd.req_type == REQ_READ_SPIN && spin_ok)
							state_q <= S_RDW;
						else if (cmd.req_type == REQ_TRIAL && spin_ok)
							state_q <= S_SUM;
						else
							state_q <= S_FIN;
					end
				end
				S_RDW: begin
					res_spin_q <= spin_rd_q;
					state_q    <= S_FIN;
				end
				S_SUM: begin
					j_q <= j_q + 1'b1;
					if (32'(j_q) == n_eff - 32'd1)
						state_q <= S_NB0;
				end
				S_NB0: state_q <= S_NB1;
				S_NB1: state_q <= S_NB2;
				S_NB2: state_q <= S_MUL;
				S_MUL: state_q <= S_RND;
				S_RND: state_q <= S_DE;
				S_DE:  state_q <= S_EXP;
				S_EXP: state_q <= S_DEC;
				S_DEC: begin
					res_flip_q <= (de_q < 0) || acc_flip;
					res_spin_q <= q_q ^ ((de_q < 0) || acc_flip);
					res_de_q   <= de_sat;
					state_q    <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_spin_q  <= res_spin_q;
						out_flip_q  <= res_flip_q;
						out_de_q    <= res_de_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.spin_out     = out_spin_q;
	assign rsp.flipped      = out_flip_q;
	assign rsp.delta_energy = out_de_q;
endmodule
`default_nettype wire
